### hdl/bmp_pkg.sv
// Shared types and constants for the BMP 24-bit to RGB555 frame writer.
package bmp_pkg;

  localparam logic [15:0] BMP_SIG          = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH        = 16'd24;
  localparam logic [31:0] HDR_BYTES        = 32'd54;
  localparam logic [31:0] FRAME_BASE_RESET = 32'h000A_0000;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_BAD_SIG   = 2'd1,
    KIND_BAD_DEPTH = 2'd2,
    KIND_BAD_SIZE  = 2'd3
  } kind_e;

  // Control from the header parser to the pixel packer, valid for one accepted byte.
  typedef struct packed {
    logic clear;     // start of a new file
    logic row_load;  // take the address of the first output row
    logic en;        // this byte belongs to the pixel array
  } pix_ctrl_t;

endpackage

### hdl/bmp_byte_if.sv
// Input channel: one file byte per request.
interface bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

### hdl/bmp_res_if.sv
// Output channel: one pixel write or status per request.
interface bmp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] byte_address;
  logic [14:0] color;
  logic        last;

  modport source (output valid, output kind, output byte_address, output color, output last,
                  input ready);
  modport sink   (input valid, input kind, input byte_address, input color, input last,
                  output ready);
endinterface

### hdl/bmp_hdr.sv
// Header parser: file phase, byte counter, header fields, checks, first row address.
module bmp_hdr #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WDW = $clog2(MAX_WIDTH + 1),
  localparam int HDW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic [7:0]               data_i,
  input  logic                     sof_i,
  input  logic [31:0]              frame_base_i,
  input  logic                     pix_last_i,
  output bmp_pkg::pix_ctrl_t       ctrl_o,
  output logic                     err_valid_o,
  output bmp_pkg::kind_e           err_kind_o,
  output logic [31:0]              row_init_o,
  output logic [WDW-1:0]           width_o,
  output logic [HDW-1:0]           height_o
);
  import bmp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [31:0] pos_q, pos_d, cur_pos;
  logic [15:0] sig_q, sig_d;
  logic [31:0] off_q, off_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] base_q, base_d;
  logic [15:0] hm1;

  function automatic logic dim_ok(logic [31:0] raw, logic [31:0] lim);
    return (raw != 32'd0) && !raw[31] && (raw <= lim);
  endfunction

  assign cur_phase = sof_i ? PH_HEADER : phase_q;
  assign cur_pos   = sof_i ? 32'd0 : pos_q;
  assign hm1       = height_q[15:0] - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sig_d       = sig_q;
    off_d       = off_q;
    width_d     = width_q;
    height_d    = height_q;
    depth_d     = depth_q;
    prod_d      = prod_q;
    base_d      = base_q;
    ctrl_o      = '0;
    err_valid_o = 1'b0;
    err_kind_o  = KIND_PIXEL;
    if (take_i) begin
      ctrl_o.clear = sof_i;
      phase_d      = cur_phase;
      if (cur_phase == PH_HEADER) begin
        pos_d = (cur_pos == '1) ? cur_pos : cur_pos + 32'd1;
        if (cur_pos < HDR_BYTES) begin
          unique case (cur_pos[5:0])
            6'd0:    sig_d[7:0]      = data_i;
            6'd1:    sig_d[15:8]     = data_i;
            6'd10:   off_d[7:0]      = data_i;
            6'd11:   off_d[15:8]     = data_i;
            6'd12:   off_d[23:16]    = data_i;
            6'd13:   off_d[31:24]    = data_i;
            6'd18:   width_d[7:0]    = data_i;
            6'd19:   width_d[15:8]   = data_i;
            6'd20:   width_d[23:16]  = data_i;
            6'd21:   width_d[31:24]  = data_i;
            6'd22:   height_d[7:0]   = data_i;
            6'd23:   height_d[15:8]  = data_i;
            6'd24:   height_d[23:16] = data_i;
            6'd25:   height_d[31:24] = data_i;
            6'd28:   depth_d[7:0]    = data_i;
            6'd29:   depth_d[15:8]   = data_i;
            default: ;
          endcase
          if (cur_pos == 32'd13 && sig_q != BMP_SIG) begin
            err_valid_o = 1'b1;
            err_kind_o  = KIND_BAD_SIG;
          end else if (cur_pos == HDR_BYTES - 32'd1) begin
            if (depth_q != BMP_DEPTH) begin
              err_valid_o = 1'b1;
              err_kind_o  = KIND_BAD_DEPTH;
            end else if (!dim_ok(width_q, 32'(MAX_WIDTH)) ||
                         !dim_ok(height_q, 32'(MAX_HEIGHT))) begin
              err_valid_o = 1'b1;
              err_kind_o  = KIND_BAD_SIZE;
            end else begin
              if (off_q < HDR_BYTES) off_d = HDR_BYTES;
              prod_d = 32'(hm1) * 32'(width_q[15:0]);
              base_d = frame_base_i;
            end
          end
        end else begin
          ctrl_o.row_load = 1'b1;
          if (cur_pos >= off_q) begin
            phase_d   = PH_PIXELS;
            ctrl_o.en = 1'b1;
          end
        end
      end else if (cur_phase == PH_PIXELS) begin
        ctrl_o.en = 1'b1;
      end
      // drop everything until the next start after an error or the final pixel
      if (err_valid_o || (ctrl_o.en && pix_last_i)) phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sig_q    <= sig_d;
    off_q    <= off_d;
    width_q  <= width_d;
    height_q <= height_d;
    depth_q  <= depth_d;
    prod_q   <= prod_d;
    base_q   <= base_d;
  end

  assign row_init_o = base_q + {prod_q[30:0], 1'b0};
  assign width_o    = width_q[WDW-1:0];
  assign height_o   = height_q[HDW-1:0];

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && err_valid_o) |=> (phase_q == PH_DONE))
    else $error("parser not done after status");
  a_pix_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.en |-> (!sof_i && (phase_q == PH_PIXELS || phase_q == PH_HEADER)))
    else $error("pixel byte outside pixel array");
endmodule

### hdl/bmp_pix.sv
// Pixel packer: BGR triplet assembly, RGB555 packing, row padding and frame addressing.
module bmp_pix #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WDW = $clog2(MAX_WIDTH + 1),
  localparam int HDW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmp_pkg::pix_ctrl_t ctrl_i,
  input  logic [7:0]         data_i,
  input  logic [31:0]        row_init_i,
  input  logic [WDW-1:0]     width_i,
  input  logic [HDW-1:0]     height_i,
  output logic               pix_valid_o,
  output logic               last_o,
  output logic [31:0]        addr_o,
  output logic [14:0]        color_o
);
  import bmp_pkg::*;

  logic [1:0]     comp_q, comp_d;
  logic [1:0]     pad_q, pad_d;
  logic [WDW-1:0] col_q, col_d, col_inc;
  logic [HDW-1:0] row_q, row_d, row_inc;
  logic [31:0]    row_addr_q, row_addr_d;
  logic [7:0]     blue_q, blue_d, green_q, green_d;
  logic           emit, col_wrap, row_wrap;

  assign col_inc  = col_q + 1'b1;
  assign row_inc  = row_q + 1'b1;
  assign col_wrap = col_inc >= width_i;
  assign row_wrap = row_inc >= height_i;
  assign emit     = (pad_q == 2'd0) && (comp_q == 2'd2);

  assign pix_valid_o = ctrl_i.en && emit;
  assign last_o      = emit && col_wrap && row_wrap;
  assign addr_o      = row_addr_q + 32'({col_q, 1'b0});
  assign color_o     = {data_i[7:3], green_q[7:3], blue_q[7:3]};

  always_comb begin
    comp_d     = comp_q;
    pad_d      = pad_q;
    col_d      = col_q;
    row_d      = row_q;
    row_addr_d = row_addr_q;
    blue_d     = blue_q;
    green_d    = green_q;
    if (ctrl_i.clear) begin
      comp_d = '0;
      pad_d  = '0;
      col_d  = '0;
      row_d  = '0;
    end
    if (ctrl_i.row_load) row_addr_d = row_init_i;
    if (ctrl_i.en) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else if (comp_q == 2'd0) begin
        blue_d = data_i;
        comp_d = 2'd1;
      end else if (comp_q == 2'd1) begin
        green_d = data_i;
        comp_d  = 2'd2;
      end else begin
        comp_d = 2'd0;
        col_d  = col_inc;
        if (col_wrap) begin
          // advance to the row above in the frame
          col_d      = '0;
          row_d      = row_inc;
          pad_d      = 2'(width_i);
          row_addr_d = row_addr_q - 32'({width_i, 1'b0});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= '0;
      pad_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      comp_q <= comp_d;
      pad_q  <= pad_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_addr_q <= row_addr_d;
    blue_q     <= blue_d;
    green_q    <= green_d;
  end
endmodule

### hdl/bmp24_to_rgb555_framewriter.sv
// Top level: BMP byte stream in, RGB555 frame writes and status out.
//
// bytes_i takes one BMP file byte per request; start_of_file marks byte 0 and
// restarts the parse at any time. Header bytes are captured and checked; the
// pixel array yields one request on results_o per BGR triplet: kind 0, the
// frame byte address of the pixel (rows flipped, padding dropped), the RGB555
// color and last on the final pixel. A bad signature, depth or size gives one
// status request of kind 1, 2 or 3, and bytes are ignored until the next start.
// cfg_we_i / cfg_wdata_i write frame_base, the frame start address.
//
// Results are registered: a result shows on results_o in the cycle after the
// byte that causes it. Throughput is one byte per cycle while the receiver
// takes results; all parsing and packing sits between the byte handshake and
// the output register. When the receiver stalls, the held result keeps
// bytes_i.ready low until it is taken; a taken result frees the register for
// a byte in the same cycle. Reset idles the parser (bytes ignored until a
// start) and sets frame_base to 0xA0000.
module bmp24_to_rgb555_framewriter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bmp_byte_if.sink    bytes_i,
  bmp_res_if.source   results_o
);
  import bmp_pkg::*;

  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);

  logic           take;
  logic [31:0]    frame_base_q;
  pix_ctrl_t      ctrl;
  logic           err_valid, pix_valid, pix_last;
  kind_e          err_kind;
  logic [31:0]    row_init, pix_addr;
  logic [14:0]    pix_color;
  logic [WDW-1:0] width;
  logic [HDW-1:0] height;

  logic           out_valid_q, out_valid_d;
  kind_e          kind_q;
  logic [31:0]    addr_q;
  logic [14:0]    color_q;
  logic           last_q;

  assign bytes_i.ready = !out_valid_q || results_o.ready;
  assign take          = bytes_i.valid && bytes_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= FRAME_BASE_RESET;
    end else if (cfg_we_i) begin
      frame_base_q <= cfg_wdata_i;
    end
  end

  bmp_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_i       (bytes_i.data_byte),
    .sof_i        (bytes_i.start_of_file),
    .frame_base_i (frame_base_q),
    .pix_last_i   (pix_last),
    .ctrl_o       (ctrl),
    .err_valid_o  (err_valid),
    .err_kind_o   (err_kind),
    .row_init_o   (row_init),
    .width_o      (width),
    .height_o     (height)
  );

  bmp_pix #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .data_i      (bytes_i.data_byte),
    .row_init_i  (row_init),
    .width_i     (width),
    .height_i    (height),
    .pix_valid_o (pix_valid),
    .last_o      (pix_last),
    .addr_o      (pix_addr),
    .color_o     (pix_color)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && (err_valid || pix_valid)) begin
      out_valid_d = 1'b1;
    end else if (results_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // load the payload only with a new request, hold it otherwise
  always_ff @(posedge clk_i) begin
    if (take && (err_valid || pix_valid)) begin
      if (err_valid) begin
        kind_q  <= err_kind;
        addr_q  <= '0;
        color_q <= '0;
        last_q  <= 1'b0;
      end else begin
        kind_q  <= KIND_PIXEL;
        addr_q  <= pix_addr;
        color_q <= pix_color;
        last_q  <= pix_last;
      end
    end
  end

  assign results_o.valid        = out_valid_q;
  assign results_o.kind         = kind_q;
  assign results_o.byte_address = addr_q;
  assign results_o.color        = color_q;
  assign results_o.last         = last_q;

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(err_valid && pix_valid))
    else $error("status and pixel in the same cycle");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_PIXEL) |-> (addr_q == '0 && color_q == '0 && !last_q))
    else $error("status request carries pixel data");
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && pix_valid) |=> out_valid_q)
    else $error("pixel request lost");
endmodule
